// File: rtl/svf_pkg.sv
// Shared types, widths and saturation helper for the state-variable filter.
`default_nettype none
package svf_pkg;

  localparam int XW = 24;
  localparam int CW = 16;
  localparam int QW = 28;
  localparam int PW = 45;
  localparam int MW = 31;
  localparam int AW = 34;
  localparam int RSH = 14;

  typedef logic signed [XW-1:0] smp_t;
  typedef logic [CW-1:0] coef_t;
  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [MW-1:0] mres_t;
  typedef logic signed [AW-1:0] acc_t;

  localparam acc_t QMAX = 34'sd134217727;
  localparam acc_t QMIN = -34'sd134217728;
  localparam prod_t RND = 45'sd8192;

  typedef struct packed {
    logic start;
    logic out_free;
  } svf_ctl_t;

  typedef struct packed {
    logic ready;
    logic done;
  } svf_stat_t;

  function automatic q_t sat_q(input acc_t v);
    q_t r;
    if (v > QMAX) begin
      r = q_t'(QMAX);
    end else if (v < QMIN) begin
      r = q_t'(QMIN);
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/svf_ifs.sv
// Request channel interfaces for filter samples and filter results.
`default_nettype none
interface svf_in_if;
  import svf_pkg::*;
  logic valid;
  logic ready;
  smp_t sample_in;
  coef_t freq_coef;
  coef_t damping_coef;
  modport source(output valid, output sample_in, output freq_coef, output damping_coef,
                 input ready);
  modport sink(input valid, input sample_in, input freq_coef, input damping_coef,
               output ready);
endinterface

interface svf_out_if;
  import svf_pkg::*;
  logic valid;
  logic ready;
  q_t lowpass_out;
  q_t highpass_out;
  q_t bandpass_out;
  q_t notch_out;
  modport source(output valid, output lowpass_out, output highpass_out,
                 output bandpass_out, output notch_out, input ready);
  modport sink(input valid, input lowpass_out, input highpass_out,
               input bandpass_out, input notch_out, output ready);
endinterface
`default_nettype wire

// File: rtl/svf_mul.sv
// Shared Q5.23 by Q2.14 multiplier with registered product and rounding.
`default_nettype none
module svf_mul (
  input  wire logic           clk,
  input  wire svf_pkg::q_t    a,
  input  wire svf_pkg::coef_t c,
  output svf_pkg::mres_t      m
);
  import svf_pkg::*;

  prod_t prod;
  prod_t biased;

  always_ff @(posedge clk) begin
    prod <= a * $signed({1'b0, c});
  end

  assign biased = prod + RND;
  assign m = biased[PW-1:RSH];

endmodule
`default_nettype wire

// File: rtl/svf_core.sv
// Pass sequencer and integrator state around the shared multiplier.
`default_nettype none
module svf_core #(
  parameter int OVERSAMPLE = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire svf_pkg::svf_ctl_t ctl,
  input  wire svf_pkg::smp_t     sample_in,
  input  wire svf_pkg::coef_t    freq_coef,
  input  wire svf_pkg::coef_t    damping_coef,
  output svf_pkg::svf_stat_t     stat,
  output svf_pkg::q_t            lp,
  output svf_pkg::q_t            hp,
  output svf_pkg::q_t            bp
);
  import svf_pkg::*;

  localparam int PCW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam logic [PCW-1:0] LAST = PCW'(OVERSAMPLE - 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL_LP = 7'b0000010,
    ST_LP     = 7'b0000100,
    ST_HP     = 7'b0001000,
    ST_MUL_BP = 7'b0010000,
    ST_BP     = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic [PCW-1:0] pass;
  smp_t x;
  coef_t f;
  coef_t d;
  q_t lps;
  q_t bps;
  q_t hpr;
  q_t mul_a;
  coef_t mul_c;
  mres_t m;

  svf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .c   (mul_c),
    .m   (m)
  );

  always_comb begin
    case (state)
      ST_LP:     begin mul_a = bps; mul_c = d; end
      ST_MUL_BP: begin mul_a = hpr; mul_c = f; end
      default:   begin mul_a = bps; mul_c = f; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (ctl.start) state_next = ST_MUL_LP;
      ST_MUL_LP: state_next = ST_LP;
      ST_LP:     state_next = ST_HP;
      ST_HP:     state_next = ST_MUL_BP;
      ST_MUL_BP: state_next = ST_BP;
      ST_BP:     state_next = (pass == LAST) ? ST_DONE : ST_MUL_LP;
      ST_DONE:   if (ctl.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass <= '0;
      lps <= '0;
      bps <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: pass <= '0;
        ST_LP:   lps <= sat_q(acc_t'(lps) + acc_t'(m));
        ST_BP: begin
          bps <= sat_q(acc_t'(m) + acc_t'(bps));
          pass <= pass + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && ctl.start) begin
      x <= sample_in;
      f <= freq_coef;
      d <= damping_coef;
    end
    if (state == ST_HP) begin
      hpr <= sat_q(acc_t'(x) - acc_t'(lps) - acc_t'(m));
    end
  end

  assign stat.ready = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE) && ctl.out_free;
  assign lp = lps;
  assign hp = hpr;
  assign bp = bps;

endmodule
`default_nettype wire

// File: rtl/state_variable_filter.sv
// Top level of the Chamberlin state-variable filter with its output register.
// Each sample request runs OVERSAMPLE passes of the two-integrator update on
// one shared multiplier; a pass steps through the MUL_LP, LP, HP, MUL_BP and
// BP states (three products plus the two additions that depend on them), and
// no new sample is accepted until the sequencer has returned to idle. A
// result the sink has not yet taken holds the sequencer in its final state
// until the output register frees up.
// The sample channel is ready only while the sequencer is idle; a finished
// result waits in the output register while the next sample is accepted.
// Integrator state is cleared by reset and saturates to the Q5.23 range.
`default_nettype none
module state_variable_filter #(
  parameter int OVERSAMPLE = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  svf_in_if.sink     sample_ch,
  svf_out_if.source  result_ch
);
  import svf_pkg::*;

  svf_ctl_t ctl;
  svf_stat_t stat;
  q_t lp;
  q_t hp;
  q_t bp;
  logic out_valid;
  q_t lp_o;
  q_t hp_o;
  q_t bp_o;
  q_t nt_o;

  assign ctl.start = sample_ch.valid && stat.ready;
  assign ctl.out_free = !out_valid || result_ch.ready;

  svf_core #(.OVERSAMPLE(OVERSAMPLE)) u_core (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sample_in    (sample_ch.sample_in),
    .freq_coef    (sample_ch.freq_coef),
    .damping_coef (sample_ch.damping_coef),
    .stat         (stat),
    .lp           (lp),
    .hp           (hp),
    .bp           (bp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      lp_o <= lp;
      hp_o <= hp;
      bp_o <= bp;
      nt_o <= sat_q(acc_t'(hp) + acc_t'(lp));
    end
  end

  assign sample_ch.ready = stat.ready;
  assign result_ch.valid = out_valid;
  assign result_ch.lowpass_out = lp_o;
  assign result_ch.highpass_out = hp_o;
  assign result_ch.bandpass_out = bp_o;
  assign result_ch.notch_out = nt_o;

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (!out_valid || result_ch.ready))
    else $error("result loaded over a pending one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
    else $error("sample accepted while a request is in flight");

  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> result_ch.valid)
    else $error("finished result not presented");

endmodule
`default_nettype wire

// File: dv/state_variable_filter_tb.sv
// Self-checking bench for the state-variable filter: directed and random sample requests.
`default_nettype none
module state_variable_filter_tb;
  import svf_pkg::*;

  localparam int OS = 4;
  localparam int RAND_PER_PHASE = 275;
  localparam longint Q_HI = 64'sd134217727;
  localparam longint Q_LO = -64'sd134217728;

  typedef struct {
    smp_t x;
    coef_t f;
    coef_t d;
  } smp_req_t;

  typedef struct {
    q_t lp;
    q_t hp;
    q_t bp;
    q_t nt;
  } bands_t;

  logic clk = 1'b0;
  logic rst;

  svf_in_if sample_ch();
  svf_out_if result_ch();

  state_variable_filter #(.OVERSAMPLE(OS)) DUT (
    .clk(clk),
    .rst(rst),
    .sample_ch(sample_ch),
    .result_ch(result_ch)
  );

  smp_req_t sample_reqs[$];
  bands_t predicted_bands[$];
  longint lp_integ;
  longint bp_integ;
  logic req_taken;
  int snd_idle_pct;
  int rcv_stall_pct;
  int bad_results;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clip_q(input longint v);
    if (v > Q_HI) begin
      return Q_HI;
    end
    if (v < Q_LO) begin
      return Q_LO;
    end
    return v;
  endfunction

  // Q5.23 times Q2.14, round half up back to Q5.23
  function automatic longint scale_q14(input longint a, input coef_t c);
    longint p;
    p = a * longint'(c);
    return (p + 64'sd8192) >>> 14;
  endfunction

  function automatic bands_t svf_predict(input smp_req_t r);
    bands_t b;
    longint x;
    longint lp;
    longint hp;
    longint bp;
    int i;
    x = longint'(r.x);
    lp = 0;
    hp = 0;
    bp = 0;
    for (i = 0; i < OS; i++) begin
      lp = clip_q(lp_integ + scale_q14(bp_integ, r.f));
      hp = clip_q(x - lp - scale_q14(bp_integ, r.d));
      bp = clip_q(scale_q14(hp, r.f) + bp_integ);
      bp_integ = bp;
      lp_integ = lp;
    end
    b.lp = q_t'(lp);
    b.hp = q_t'(hp);
    b.bp = q_t'(bp);
    b.nt = q_t'(clip_q(hp + lp));
    return b;
  endfunction

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    smp_req_t r;
    bands_t want;
    req_taken = 1'b0;
    if (rst) begin
      lp_integ = 0;
      bp_integ = 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        req_taken = 1'b1;
        r.x = sample_ch.sample_in;
        r.f = sample_ch.freq_coef;
        r.d = sample_ch.damping_coef;
        predicted_bands.push_back(svf_predict(r));
      end
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_bands.size() == 0) begin
          if (bad_results < 10) begin
            $display("unexpected result lp=%0d hp=%0d bp=%0d nt=%0d",
                     result_ch.lowpass_out, result_ch.highpass_out,
                     result_ch.bandpass_out, result_ch.notch_out);
          end
          bad_results++;
        end else begin
          want = predicted_bands.pop_front();
          if (result_ch.lowpass_out !== want.lp || result_ch.highpass_out !== want.hp ||
              result_ch.bandpass_out !== want.bp || result_ch.notch_out !== want.nt) begin
            if (bad_results < 10) begin
              $display("mismatch exp lp=%0d hp=%0d bp=%0d nt=%0d", want.lp, want.hp,
                       want.bp, want.nt);
              $display("         got lp=%0d hp=%0d bp=%0d nt=%0d",
                       result_ch.lowpass_out, result_ch.highpass_out,
                       result_ch.bandpass_out, result_ch.notch_out);
            end
            bad_results++;
          end
        end
      end
    end
  end

  // driver: requests and result backpressure change on the falling edge
  always @(negedge clk) begin
    smp_req_t r;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      result_ch.ready <= 1'b0;
    end else begin
      if (!sample_ch.valid || req_taken) begin
        if (sample_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          r = sample_reqs.pop_front();
          sample_ch.valid <= 1'b1;
          sample_ch.sample_in <= r.x;
          sample_ch.freq_coef <= r.f;
          sample_ch.damping_coef <= r.d;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
      result_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic push_req(input int x, input int f, input int d);
    smp_req_t r;
    r.x = smp_t'(x);
    r.f = coef_t'(f);
    r.d = coef_t'(d);
    sample_reqs.push_back(r);
  endtask

  task automatic drain_all();
    while (sample_reqs.size() != 0 || sample_ch.valid || predicted_bands.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    smp_req_t r;
    int ph;
    int n;
    int k;
    sample_ch.valid = 1'b0;
    sample_ch.sample_in = '0;
    sample_ch.freq_coef = '0;
    sample_ch.damping_coef = '0;
    result_ch.ready = 1'b0;
    req_taken = 1'b0;
    lp_integ = 0;
    bp_integ = 0;
    bad_results = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // field extremes, saturation of state, zero damping, decay from zero input
    push_req(0, 0, 0);
    push_req(8388607, 0, 0);
    push_req(-8388608, 0, 0);
    push_req(8388607, 16384, 16384);
    push_req(-8388608, 16384, 16384);
    push_req(8388607, 65535, 65535);
    push_req(-8388608, 65535, 65535);
    push_req(8388607, 65535, 0);
    push_req(-8388608, 65535, 0);
    push_req(0, 32768, 65535);
    push_req(0, 2000, 20000);
    push_req(0, 2000, 20000);
    push_req(0, 2000, 20000);
    push_req(8388607, 32767, 1);
    push_req(-1, 1, 65535);
    push_req(0, 0, 65535);
    push_req(4194304, 8000, 23170);
    push_req(-4194304, 8000, 23170);
    push_req(0, 16384, 32768);
    push_req(0, 16384, 32768);
    drain_all();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct = 55;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 55;
        end
        default: begin
          snd_idle_pct = 9;
          rcv_stall_pct = 9;
        end
      endcase
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        k = $urandom_range(9);
        r.x = smp_t'($urandom);
        if (k < 7) begin
          // audio-range coefficients
          r.f = coef_t'($urandom_range(12000));
          r.d = coef_t'($urandom_range(40000, 1500));
        end else if (k < 9) begin
          r.f = coef_t'($urandom);
          r.d = coef_t'($urandom);
        end else begin
          // silence lets saturated state recover
          r.x = '0;
          r.f = coef_t'($urandom_range(12000));
          r.d = coef_t'($urandom_range(40000, 1500));
        end
        sample_reqs.push_back(r);
      end
      drain_all();
    end

    repeat (30) @(posedge clk);
    if (bad_results == 0 && predicted_bands.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
